### rtl/mmct_pkg.sv
// Package for the min/max calibration tracker: axis width, reset timeout
// and the operation codes. No dependencies.
package mmct_pkg;

  localparam int unsigned AXIS_BITS = 16;
  localparam int unsigned TIME_BITS = 32;

  localparam logic [TIME_BITS-1:0] TIMEOUT_RST = TIME_BITS'(5000);

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef logic signed [AXIS_BITS-1:0] axis_t;
  typedef logic [TIME_BITS-1:0] time_t;

endpackage

### rtl/axis_min_max_calibration_tracker.sv
// Top level of the min/max calibration tracker: input register, extreme
// update and timeout logic, result register. Depends on mmct_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   operation, x/y/z_sample, now_ms
//   out      source     out_valid_o / out_stall_i changed, done_res, finished_now,
//                                                 x/y/z_low, x/y/z_high
//   cfg      sink       cfg_wr_en_i               cfg_wr_data_i (idle_timeout_ms)
//
// One beat is taken every cycle unless a stalled result holds it back; its result
// passes through the input register and then the result register.
// The compare, subtract and timeout compare sit between those two registers.
// Reset clears the extremes and the last change time and marks calibration done.
// A stalled result holds; the input register still takes one more beat behind it.
module axis_min_max_calibration_tracker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   operation_i,
  input  logic signed [mmct_pkg::AXIS_BITS-1:0]  x_sample_i,
  input  logic signed [mmct_pkg::AXIS_BITS-1:0]  y_sample_i,
  input  logic signed [mmct_pkg::AXIS_BITS-1:0]  z_sample_i,
  input  logic        [mmct_pkg::TIME_BITS-1:0]  now_ms_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   changed_o,
  output logic                                   done_res_o,
  output logic                                   finished_now_o,
  output logic signed [mmct_pkg::AXIS_BITS-1:0]  x_low_o,
  output logic signed [mmct_pkg::AXIS_BITS-1:0]  x_high_o,
  output logic signed [mmct_pkg::AXIS_BITS-1:0]  y_low_o,
  output logic signed [mmct_pkg::AXIS_BITS-1:0]  y_high_o,
  output logic signed [mmct_pkg::AXIS_BITS-1:0]  z_low_o,
  output logic signed [mmct_pkg::AXIS_BITS-1:0]  z_high_o,
  input  logic                                   cfg_wr_en_i,
  input  logic        [mmct_pkg::TIME_BITS-1:0]  cfg_wr_data_i
);
  import mmct_pkg::*;

  // Input register.
  logic  s1_vld_q;
  op_e   s1_op_q;
  axis_t s1_smp_q [3];
  time_t s1_now_q;

  // Calibration state; the extremes double as the result's extreme fields.
  axis_t lo_q [3];
  axis_t lo_d [3];
  axis_t hi_q [3];
  axis_t hi_d [3];
  time_t last_q;
  time_t last_d;
  logic  fin_q;
  logic  fin_d;
  time_t timeout_q;

  // Result register.
  logic  out_vld_q;
  logic  chg_q;
  logic  chg_d;
  logic  fin_now_q;
  logic  fin_now_d;

  logic  advance;
  logic  s1_load;
  time_t elapsed;

  assign advance    = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !advance;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_load) begin
      s1_vld_q <= 1'b1;
    end else if (advance) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q     <= op_e'(operation_i);
      s1_smp_q[0] <= x_sample_i;
      s1_smp_q[1] <= y_sample_i;
      s1_smp_q[2] <= z_sample_i;
      s1_now_q    <= now_ms_i;
    end
  end

  always_comb begin
    chg_d     = 1'b0;
    fin_now_d = 1'b0;
    fin_d     = fin_q;
    last_d    = last_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    elapsed   = '0;
    case (s1_op_q)
      OP_START: begin
        lo_d   = s1_smp_q;
        hi_d   = s1_smp_q;
        last_d = s1_now_q;
        fin_d  = 1'b0;
      end
      OP_SAMPLE: begin
        if (!fin_q) begin
          // Each axis lowers its minimum, or else raises its maximum.
          for (int a = 0; a < 3; a++) begin
            if (s1_smp_q[a] < lo_q[a]) begin
              lo_d[a] = s1_smp_q[a];
              chg_d   = 1'b1;
            end else if (s1_smp_q[a] > hi_q[a]) begin
              hi_d[a] = s1_smp_q[a];
              chg_d   = 1'b1;
            end
          end
          if (chg_d) begin
            last_d = s1_now_q;
          end
          elapsed = s1_now_q - last_d;
          if (elapsed > timeout_q) begin
            fin_d     = 1'b1;
            fin_now_d = 1'b1;
          end
        end
      end
      default: begin
        fin_d = fin_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= '0;
        hi_q[a] <= '0;
      end
      last_q <= '0;
      fin_q  <= 1'b1;
    end else if (advance) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      last_q <= last_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_wr_en_i) begin
      timeout_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      chg_q     <= chg_d;
      fin_now_q <= fin_now_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign changed_o      = chg_q;
  assign done_res_o     = fin_q;
  assign finished_now_o = fin_now_q;
  assign x_low_o        = lo_q[0];
  assign x_high_o       = hi_q[0];
  assign y_low_o        = lo_q[1];
  assign y_high_o       = hi_q[1];
  assign z_low_o        = lo_q[2];
  assign z_high_o       = hi_q[2];

endmodule

### rtl/mmct_checker.sv
// Port-level checker for the min/max calibration tracker and its bind.
// Depends on mmct_pkg and the top level's port list.
module mmct_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic                                   changed_o,
  input logic                                   done_res_o,
  input logic                                   finished_now_o,
  input logic signed [mmct_pkg::AXIS_BITS-1:0]  x_low_o,
  input logic signed [mmct_pkg::AXIS_BITS-1:0]  x_high_o,
  input logic signed [mmct_pkg::AXIS_BITS-1:0]  y_low_o,
  input logic signed [mmct_pkg::AXIS_BITS-1:0]  y_high_o,
  input logic signed [mmct_pkg::AXIS_BITS-1:0]  z_low_o,
  input logic signed [mmct_pkg::AXIS_BITS-1:0]  z_high_o
);
  import mmct_pkg::*;

  // A beat that ends calibration cannot also carry a new extreme.
  a_finish_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_now_o |-> done_res_o && !changed_o)
    else $error("finishing beat is not done or reports a change");

  // A change restarts the idle time, so calibration is still running.
  a_change_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_o |-> !done_res_o)
    else $error("changed beat reports calibration done");

  // Minimum never passes maximum on any axis.
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_low_o <= x_high_o && y_low_o <= y_high_o && z_low_o <= z_high_o)
    else $error("an axis minimum exceeds its maximum");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(changed_o)
      && $stable(done_res_o) && $stable(finished_now_o) && $stable(x_low_o)
      && $stable(x_high_o) && $stable(y_low_o) && $stable(y_high_o)
      && $stable(z_low_o) && $stable(z_high_o))
    else $error("stalled result beat changed");

endmodule

bind axis_min_max_calibration_tracker mmct_checker u_mmct_checker (.*);

### bench/axis_min_max_calibration_tracker_tb.sv
// Self-checking bench for axis_min_max_calibration_tracker: directed extremes,
// timeout and wrap cases, back-pressure and random calibration runs.
// Depends on mmct_pkg and the tracker RTL only.
`timescale 1ns / 100ps

module axis_min_max_calibration_tracker_tb;
  import mmct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic            changed;
    logic            done;
    logic            fin_now;
    axis_t [5:0]     ext;
  } calib_res_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  op_e   operation;
  axis_t x_sample;
  axis_t y_sample;
  axis_t z_sample;
  time_t now_ms;
  logic  out_valid;
  logic  out_stall;
  logic  changed;
  logic  done_res;
  logic  finished_now;
  axis_t x_low, x_high, y_low, y_high, z_low, z_high;
  logic  cfg_wr_en;
  time_t cfg_wr_data;

  // Shadow copy of the tracker state.
  axis_t ext_st [6];
  time_t last_chg_st;
  logic  fin_st;
  time_t tmo_st;

  calib_res_t expected_q [$];
  int unsigned errors;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned timeouts_hit;
  int unsigned cfg_writes;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_req;
  int unsigned hold_left;

  string ext_names [6] = '{"x_low", "x_high", "y_low", "y_high", "z_low", "z_high"};

  axis_min_max_calibration_tracker dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .x_sample_i     (x_sample),
    .y_sample_i     (y_sample),
    .z_sample_i     (z_sample),
    .now_ms_i       (now_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .changed_o      (changed),
    .done_res_o     (done_res),
    .finished_now_o (finished_now),
    .x_low_o        (x_low),
    .x_high_o       (x_high),
    .y_low_o        (y_low),
    .y_high_o       (y_high),
    .z_low_o        (z_low),
    .z_high_o       (z_high),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic calib_res_t update_extremes(input op_e op, input axis_t xs, input axis_t ys,
                                                 input axis_t zs, input time_t now);
    calib_res_t r;
    axis_t      s [3];
    int         a;
    s[0] = xs;
    s[1] = ys;
    s[2] = zs;
    r.changed = 1'b0;
    r.fin_now = 1'b0;
    if (op == OP_START) begin
      for (a = 0; a < 3; a++) begin
        ext_st[2*a]   = s[a];
        ext_st[2*a+1] = s[a];
      end
      last_chg_st = now;
      fin_st      = 1'b0;
    end else if (!fin_st) begin
      // Each axis either lowers its minimum or raises its maximum, never both.
      for (a = 0; a < 3; a++) begin
        if (s[a] < ext_st[2*a]) begin
          ext_st[2*a] = s[a];
          r.changed   = 1'b1;
        end else if (s[a] > ext_st[2*a+1]) begin
          ext_st[2*a+1] = s[a];
          r.changed     = 1'b1;
        end
      end
      if (r.changed) last_chg_st = now;
      if (time_t'(now - last_chg_st) > tmo_st) begin
        fin_st    = 1'b1;
        r.fin_now = 1'b1;
        timeouts_hit++;
      end
    end
    r.done = fin_st;
    for (a = 0; a < 6; a++) r.ext[a] = ext_st[a];
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_beat(input op_e op, input axis_t xs, input axis_t ys, input axis_t zs,
                           input time_t now);
    bit taken;
    if (tx_idle_on && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    x_sample  = xs;
    y_sample  = ys;
    z_sample  = zs;
    now_ms    = now;
    taken     = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      if (taken) begin
        expected_q.push_back(update_extremes(op, xs, ys, zs, now));
        beats_sent++;
      end
      @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout(input time_t value);
    stop_sending();
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tmo_st    = value;
    cfg_writes++;
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    calib_res_t want;
    calib_res_t got;
    int         i;
    got.changed = changed;
    got.done    = done_res;
    got.fin_now = finished_now;
    got.ext[0]  = x_low;
    got.ext[1]  = x_high;
    got.ext[2]  = y_low;
    got.ext[3]  = y_high;
    got.ext[4]  = z_low;
    got.ext[5]  = z_high;
    if (expected_q.size() == 0) begin
      $error("Result beat arrived with no input beat outstanding");
      errors++;
    end else begin
      want = expected_q.pop_front();
      results_seen++;
      compare_field("changed", {31'b0, want.changed}, {31'b0, got.changed});
      compare_field("done_res", {31'b0, want.done}, {31'b0, got.done});
      compare_field("finished_now", {31'b0, want.fin_now}, {31'b0, got.fin_now});
      for (i = 0; i < 6; i++) compare_field(ext_names[i], $signed(want.ext[i]),
                                            $signed(got.ext[i]));
    end
  endtask

  // Result side: random stalls plus requested hold-offs, changed at the falling edge.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = rx_idle_on && ($urandom_range(0, 99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  function automatic axis_t near(input axis_t center, input int spread);
    return axis_t'(int'(center) + $urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic test_before_start();
    // Reset leaves calibration finished, so samples change nothing.
    send_beat(OP_SAMPLE, 16'sh7fff, -16'sd32768, 16'sd5, 32'd0);
    send_beat(OP_SAMPLE, -16'sd32768, 16'sh7fff, -16'sd5, 32'hffff_ffff);
  endtask

  task automatic test_extremes_and_wrap();
    send_beat(OP_START, 16'sd0, -16'sd1, 16'sd1, 32'd100);
    send_beat(OP_SAMPLE, -16'sd32768, 16'sh7fff, 16'sd1, 32'd200);
    send_beat(OP_SAMPLE, 16'sh7fff, -16'sd32768, -16'sd32768, 32'd300);
    // Values equal to the extremes are not a change.
    send_beat(OP_SAMPLE, 16'sh7fff, 16'sh7fff, -16'sd32768, 32'd300);
    // Elapsed time equal to the timeout does not end calibration; one more does.
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd5300);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd5301);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 16'sh7fff, 32'd5302);
    // Elapsed time across the 32-bit wrap.
    send_beat(OP_START, 16'sd10, 16'sd20, 16'sd30, 32'hffff_f000);
    send_beat(OP_SAMPLE, 16'sd10, 16'sd20, 16'sd30, 32'h0000_0388);
    send_beat(OP_SAMPLE, 16'sd10, 16'sd20, 16'sd30, 32'h0000_0389);
    // A change and a long gap on one sample restarts the idle time instead.
    send_beat(OP_START, 16'sd0, 16'sd0, 16'sd0, 32'd1000);
    send_beat(OP_SAMPLE, 16'sd1, -16'sd1, 16'sd0, 32'd900000);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd905000);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd905001);
  endtask

  task automatic test_timeout_limits();
    write_timeout(32'd0);
    send_beat(OP_START, -16'sd100, 16'sd100, 16'sd0, 32'd7);
    send_beat(OP_SAMPLE, -16'sd100, 16'sd100, 16'sd0, 32'd7);
    send_beat(OP_SAMPLE, -16'sd100, 16'sd100, 16'sd0, 32'd8);
    write_timeout(32'hffff_ffff);
    send_beat(OP_START, 16'sd0, 16'sd0, 16'sd0, 32'd0);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'hffff_ffff);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'h8000_0000);
    write_timeout(32'd5000);
  endtask

  task automatic test_backpressure();
    int    i;
    time_t t;
    stop_sending();
    tx_idle_on = 1'b0;
    @(posedge clk);
    hold_req = 60;
    @(negedge clk);
    t = $urandom;
    send_beat(OP_START, 16'sd0, 16'sd0, 16'sd0, t);
    for (i = 0; i < 20; i++) begin
      t = t + $urandom_range(0, 800);
      send_beat(OP_SAMPLE, near(16'sd0, 50), near(16'sd0, 50), near(16'sd0, 50), t);
    end
    // The sender now waits for every outstanding result before going on.
    stop_sending();
    wait_drained();
    @(negedge clk);
    for (i = 0; i < 5; i++) begin
      t = t + $urandom_range(0, 3000);
      send_beat(OP_SAMPLE, near(16'sd0, 80), near(16'sd0, 80), near(16'sd0, 80), t);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic run_calibration(input int n_samples);
    axis_t cx, cy, cz;
    time_t t;
    int    spread;
    int    i;
    int    r;
    op_e   op;
    t      = $urandom;
    spread = $urandom_range(1, 300);
    if ($urandom_range(0, 4) == 0) begin
      cx = axis_t'($urandom);
      cy = axis_t'($urandom);
      cz = axis_t'($urandom);
    end else begin
      cx = near(16'sd0, 2000);
      cy = near(16'sd0, 2000);
      cz = near(16'sd0, 2000);
    end
    send_beat(OP_START, cx, cy, cz, t);
    for (i = 0; i < n_samples; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) t = t + $urandom_range(0, 40);
      else if (r < 80) t = t + tmo_st + $urandom_range(0, 2) - 1;
      else t = t + $urandom;
      op = ($urandom_range(0, 99) < 5) ? OP_START : OP_SAMPLE;
      if ($urandom_range(0, 99) < 70)
        send_beat(op, near(cx, spread), near(cy, spread), near(cz, spread), t);
      else
        send_beat(op, axis_t'($urandom), axis_t'($urandom), axis_t'($urandom), t);
    end
  endtask

  task automatic test_random();
    time_t tmo_list [8];
    int    phase;
    int    start_count;
    tmo_list = '{32'd0, 32'd1, 32'd37, 32'd5000, time_t'($urandom_range(100, 3000)),
                 time_t'($urandom), 32'hffff_ffff, 32'd250};
    for (phase = 0; phase < 8; phase++) begin
      write_timeout(tmo_list[phase]);
      // One phase runs with both sides streaming without any gaps.
      tx_idle_on  = (phase != 3);
      rx_idle_on  = (phase != 3);
      start_count = beats_sent;
      while (beats_sent - start_count < 45) run_calibration($urandom_range(5, 30));
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    operation   = OP_SAMPLE;
    x_sample    = '0;
    y_sample    = '0;
    z_sample    = '0;
    now_ms      = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    hold_req    = 0;
    for (int i = 0; i < 6; i++) ext_st[i] = '0;
    last_chg_st = '0;
    fin_st      = 1'b1;
    tmo_st      = TIMEOUT_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_before_start();
    test_extremes_and_wrap();
    test_timeout_limits();
    test_backpressure();
    test_random();

    stop_sending();
    wait_drained();
    repeat (8) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      errors++;
    end
    $display("Sent %0d input beats, checked %0d result beats, %0d timeout writes.",
             beats_sent, results_seen, cfg_writes);
    $display("Calibration ended on timeout %0d times; %0d mismatches.", timeouts_hit, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
